// ----- rtl/core/tsp_pkg.sv -----
// ============================================================================
// tsp_pkg: shared types and constants of the timestamp text parser
// Character codes, status and scale codes, the per-timestamp request record
// and the field weight table.
// ============================================================================
package tsp_pkg;

    localparam int MAX_FIELDS = 4;
    localparam int IDX_W      = 2;   // index into the closed-field slots
    localparam int COUNT_W    = 3;   // holds 0 .. MAX_FIELDS + 1
    localparam int WEIGHT_W   = 22;  // holds 3_600_000
    localparam int MS_W       = 31;

    localparam logic [MS_W-1:0] MS_MAX = 31'h7FFF_FFFF;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_TOO_MANY = 2'd2
    } status_t;

    // Scaling of a short fraction that closes at end of text.
    typedef enum logic [1:0] {
        SC_ONE     = 2'd0,
        SC_TEN     = 2'd1,
        SC_HUNDRED = 2'd2
    } scale_t;

    // Control part of one finished timestamp, passed from front to back.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               seen_dec;
        scale_t             scale;
        status_t            status;
    } frame_ctrl_t;

    // Weight of a field by its place counted from the right, starting at 1.
    function automatic logic [WEIGHT_W-1:0] weight_of(input logic [COUNT_W-1:0] idx);
        logic [WEIGHT_W-1:0] w;
        case (idx)
            3'd1:    w = 22'd1;
            3'd2:    w = 22'd1000;
            3'd3:    w = 22'd60000;
            3'd4:    w = 22'd3600000;
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [WEIGHT_W-1:0] scale_weight(input scale_t sc);
        logic [WEIGHT_W-1:0] w;
        case (sc)
            SC_TEN:     w = 22'd10;
            SC_HUNDRED: w = 22'd100;
            default:    w = 22'd1;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/timestamp_text_parser.sv -----
// ============================================================================
// timestamp_text_parser: h:m:s.fff text to milliseconds
// Parses a timestamp text stream, one character per request, into a total
// millisecond count and a status code at the character marked last.
// ============================================================================
// Throughput: one character per cycle while the sink accepts; the back end
//   retires one timestamp per cycle, so even one-character timestamps flow at full rate.
// Path: the last character is written into the queue at the accepting edge,
//   then passes the weighting multiply stage and the sum stage; both stages
//   hold under back-pressure from the sink.
// Reset: rst_n clears all parser control state and empties the queue and
//   pipeline; field value storage is not cleared and needs no clearing pass.
module timestamp_text_parser #(
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] milliseconds, [31] zero pad
    output logic [1:0]  m_tuser    // [1:0] status
);
    import tsp_pkg::*;

    localparam int FIELDS_W = MAX_FIELDS * VALUE_BITS;
    localparam int CTRL_W   = $bits(frame_ctrl_t);
    localparam int REC_W    = FIELDS_W + CTRL_W;

    // Front end to queue
    logic                                  fr_valid;
    logic                                  fr_ready;
    logic [MAX_FIELDS-1:0][VALUE_BITS-1:0] fr_fields;
    frame_ctrl_t                           fr_ctrl;

    // Queue to back end
    logic                                  bk_valid;
    logic                                  bk_ready;
    logic [REC_W-1:0]                      bk_data;
    logic [MAX_FIELDS-1:0][VALUE_BITS-1:0] bk_fields;
    frame_ctrl_t                           bk_ctrl;

    logic [MS_W-1:0]                       res_ms;
    status_t                               res_status;

    // Classify characters and build fields; emit a request per timestamp.
    tsp_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_char   (s_tdata),
        .in_last   (s_tlast),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_fields(fr_fields),
        .out_ctrl  (fr_ctrl)
    );

    // Hold finished timestamps while the back end or the sink stalls.
    tsp_queue #(
        .DATA_W(REC_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fr_valid),
        .in_ready (fr_ready),
        .in_data  ({fr_fields, fr_ctrl}),
        .out_valid(bk_valid),
        .out_ready(bk_ready),
        .out_data (bk_data)
    );

    assign bk_fields = bk_data[REC_W-1:CTRL_W];
    assign bk_ctrl   = bk_data[CTRL_W-1:0];

    // Weight fields, sum and saturate.
    tsp_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bk_valid),
        .in_ready  (bk_ready),
        .in_fields (bk_fields),
        .in_ctrl   (bk_ctrl),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ms    (res_ms),
        .out_status(res_status)
    );

    assign m_tdata = {1'b0, res_ms};
    assign m_tuser = res_status;

    // A failed parse never reports a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != 2'(ST_OK))) |-> (m_tdata[MS_W-1:0] == '0))
        else $error("nonzero milliseconds with error status");

    // The front end only emits while the queue has room.
    assert property (@(posedge clk) disable iff (!rst_n)
        fr_valid |-> fr_ready)
        else $error("request pushed into a full queue");

    // A timestamp that is accepted leaves the front end with an empty queue
    // slot being used: the queue reports data on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> bk_valid)
        else $error("finished timestamp missing from queue");

endmodule

// ----- rtl/core/tsp_front.sv -----
// ============================================================================
// tsp_front: character classifier and field builder
// Builds field values one character per cycle while the queue has room and
// emits one request with all closed fields when the last character arrives.
// ============================================================================
module tsp_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [7:0]                                   in_char,
    input  logic                                         in_last,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [tsp_pkg::MAX_FIELDS-1:0][VALUE_BITS-1:0] out_fields,
    output tsp_pkg::frame_ctrl_t                         out_ctrl
);
    import tsp_pkg::*;

    localparam int EXT_W = VALUE_BITS + 4;

    logic [MAX_FIELDS-1:0][VALUE_BITS-1:0] field_reg, field_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [VALUE_BITS-1:0] running_reg, running_next;
    logic [1:0]            digits_reg, digits_next;
    logic                  dec_reg, dec_next;
    logic                  stop_reg, stop_next;
    status_t               err_reg, err_next;

    logic                  accept;
    logic                  active;
    logic                  is_dec, is_sep, is_space, is_digit;
    logic [EXT_W-1:0]      run_ext, digit_prod;
    logic [VALUE_BITS-1:0] digit_sat;
    logic [1:0]            digits_inc;
    logic                  close_req;
    logic [VALUE_BITS-1:0] close_val;

    assign in_ready  = out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = accept && in_last;

    assign active   = !stop_reg && (err_reg == ST_OK);
    assign is_dec   = (in_char == CH_DOT) || (in_char == CH_COMMA);
    assign is_sep   = is_dec || (in_char == CH_COLON) || (in_char == CH_SEMI);
    assign is_space = (in_char == CH_SPACE);
    assign is_digit = in_char inside {[CH_ZERO:CH_NINE]};

    // running * 10 + digit, saturated at the field maximum
    assign run_ext    = EXT_W'(running_reg);
    assign digit_prod = (run_ext << 3) + (run_ext << 1) + EXT_W'(in_char[3:0]);
    assign digit_sat  = (digit_prod[EXT_W-1:VALUE_BITS] != '0) ? '1
                                                              : digit_prod[VALUE_BITS-1:0];
    assign digits_inc = (digits_reg == 2'd3) ? 2'd3 : digits_reg + 2'd1;

    always_comb
    begin
        field_next   = field_reg;
        count_next   = count_reg;
        running_next = running_reg;
        digits_next  = digits_reg;
        dec_next     = dec_reg;
        stop_next    = stop_reg;
        err_next     = err_reg;
        close_req    = 1'b0;
        close_val    = running_reg;
        if (active)
        begin
            if (is_sep)
            begin
                if (is_dec && dec_reg)
                begin
                    stop_next = 1'b1;
                end
                else
                begin
                    dec_next     = dec_reg | is_dec;
                    close_req    = 1'b1;
                    running_next = '0;
                    digits_next  = 2'd0;
                end
            end
            else if (!is_space)
            begin
                if (!is_digit)
                begin
                    err_next = ST_BAD_CHAR;
                end
                else
                begin
                    running_next = digit_sat;
                    digits_next  = digits_inc;
                    // third fraction digit ends the text
                    if (dec_reg && (digits_inc == 2'd3))
                    begin
                        close_req = 1'b1;
                        close_val = digit_sat;
                        stop_next = 1'b1;
                    end
                end
            end
        end
        if (close_req)
        begin
            if (count_reg >= COUNT_W'(MAX_FIELDS))
            begin
                err_next = ST_TOO_MANY;
            end
            else
            begin
                field_next[count_reg[IDX_W-1:0]] = close_val;
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Close the open field at end of text and check the field budget.
    always_comb
    begin
        out_fields        = field_next;
        out_ctrl.count    = count_next;
        out_ctrl.seen_dec = dec_next;
        out_ctrl.scale    = SC_ONE;
        out_ctrl.status   = err_next;
        if (!stop_next && (err_next == ST_OK))
        begin
            if (count_next >= COUNT_W'(MAX_FIELDS))
            begin
                out_ctrl.status = ST_TOO_MANY;
            end
            else
            begin
                out_fields[count_next[IDX_W-1:0]] = running_next;
                out_ctrl.count = count_next + 1'b1;
                if (dec_next)
                begin
                    case (digits_next)
                        2'd1:    out_ctrl.scale = SC_HUNDRED;
                        2'd2:    out_ctrl.scale = SC_TEN;
                        default: out_ctrl.scale = SC_ONE;
                    endcase
                end
            end
        end
        if ((out_ctrl.status == ST_OK) &&
            ((out_ctrl.count + COUNT_W'(!dec_next)) > COUNT_W'(MAX_FIELDS)))
        begin
            out_ctrl.status = ST_TOO_MANY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            running_reg <= '0;
            digits_reg  <= 2'd0;
            dec_reg     <= 1'b0;
            stop_reg    <= 1'b0;
            err_reg     <= ST_OK;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                count_reg   <= '0;
                running_reg <= '0;
                digits_reg  <= 2'd0;
                dec_reg     <= 1'b0;
                stop_reg    <= 1'b0;
                err_reg     <= ST_OK;
            end
            else
            begin
                count_reg   <= count_next;
                running_reg <= running_next;
                digits_reg  <= digits_next;
                dec_reg     <= dec_next;
                stop_reg    <= stop_next;
                err_reg     <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !in_last)
        begin
            field_reg <= field_next;
        end
    end

endmodule

// ----- rtl/core/tsp_queue.sv -----
// ============================================================================
// tsp_queue: two-entry request queue
// Decouples the character front end from the weighting back end.
// ============================================================================
module tsp_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);
    logic [1:0][DATA_W-1:0] mem_reg;
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             cnt_reg, cnt_next;
    logic                   push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    assign wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
    assign cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ----- rtl/core/tsp_back.sv -----
// ============================================================================
// tsp_back: field weighting and total
// Multiplies each field by its weight, clips, sums and saturates in two
// pipelined stages, the second of which is the output register.
// ============================================================================
module tsp_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  logic [tsp_pkg::MAX_FIELDS-1:0][VALUE_BITS-1:0] in_fields,
    input  tsp_pkg::frame_ctrl_t                           in_ctrl,
    output logic                                           out_valid,
    input  logic                                           out_ready,
    output logic [tsp_pkg::MS_W-1:0]                       out_ms,
    output tsp_pkg::status_t                               out_status
);
    import tsp_pkg::*;

    localparam int PROD_W = VALUE_BITS + WEIGHT_W;
    localparam int SUM_W  = MS_W + 2;
    // A scaled fraction saturates as a field before it is weighted by one.
    localparam logic [MS_W-1:0] SCALED_CAP =
        (VALUE_BITS >= MS_W) ? MS_MAX : MS_W'((64'd1 << VALUE_BITS) - 64'd1);

    logic [MAX_FIELDS-1:0]                 slot_used, slot_scaled;
    logic [MAX_FIELDS-1:0][COUNT_W-1:0]    slot_idx;
    logic [MAX_FIELDS-1:0][WEIGHT_W-1:0]   slot_weight;
    logic [MAX_FIELDS-1:0][VALUE_BITS-1:0] slot_operand;
    logic [MAX_FIELDS-1:0][PROD_W-1:0]     slot_prod;
    logic [MAX_FIELDS-1:0][MS_W-1:0]       slot_cap;
    logic [MAX_FIELDS-1:0][MS_W-1:0]       term_next;

    logic                            s1_valid_reg;
    logic [MAX_FIELDS-1:0][MS_W-1:0] term_reg;
    status_t                         s1_status_reg;

    logic                            out_valid_reg;
    logic [MS_W-1:0]                 out_ms_reg, out_ms_next;
    status_t                         out_status_reg;
    logic [SUM_W-1:0]                sum;

    logic                            out_take;
    logic                            s1_take;

    assign out_take = !out_valid_reg || out_ready;
    assign s1_take  = !s1_valid_reg || out_take;
    assign in_ready = s1_take;

    // Weight slots from the right: the rightmost closed field gets place one,
    // or place two when no fraction was seen.
    always_comb
    begin
        for (int j = 0; j < MAX_FIELDS; j++)
        begin
            slot_used[j]    = COUNT_W'(j) < in_ctrl.count;
            slot_idx[j]     = in_ctrl.count - COUNT_W'(j) + COUNT_W'(!in_ctrl.seen_dec);
            slot_scaled[j]  = slot_used[j] && (COUNT_W'(j) + 1'b1 == in_ctrl.count) &&
                              (in_ctrl.scale != SC_ONE);
            slot_weight[j]  = slot_scaled[j] ? scale_weight(in_ctrl.scale)
                            : (slot_used[j] ? weight_of(slot_idx[j]) : '0);
            slot_operand[j] = slot_used[j] ? in_fields[j] : '0;
            slot_prod[j]    = PROD_W'(slot_operand[j]) * PROD_W'(slot_weight[j]);
            slot_cap[j]     = slot_scaled[j] ? SCALED_CAP : MS_MAX;
            term_next[j]    = (slot_prod[j] > PROD_W'(slot_cap[j])) ? slot_cap[j]
                                                                    : slot_prod[j][MS_W-1:0];
        end
    end

    always_comb
    begin
        sum = '0;
        for (int j = 0; j < MAX_FIELDS; j++)
        begin
            sum = sum + SUM_W'(term_reg[j]);
        end
        if (s1_status_reg != ST_OK)
        begin
            out_ms_next = '0;
        end
        else if (sum > SUM_W'(MS_MAX))
        begin
            out_ms_next = MS_MAX;
        end
        else
        begin
            out_ms_next = sum[MS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_take)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take && in_valid)
        begin
            term_reg      <= term_next;
            s1_status_reg <= in_ctrl.status;
        end
        if (out_take && s1_valid_reg)
        begin
            out_ms_reg     <= out_ms_next;
            out_status_reg <= s1_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_ms     = out_ms_reg;
    assign out_status = out_status_reg;

endmodule
